[rtl/ldr_pkg.sv]
// Shared types for the logistic dose-response unit: item class and queued word.
package ldr_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_OVER_MAX   = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SCALE = 2'd2;

   // Class of an item, settled by the front end
   typedef enum logic [1:0] {
      KIND_NORMAL,
      KIND_OVER_MAX,
      KIND_ZERO_SCALE,
      KIND_ZERO_CONC
   } kind_type;

   // Word passed from front end to back end through the queue
   typedef struct packed {
      kind_type    kind;
      logic        scale_neg;
      logic [4:0]  conc_exp;
      logic [31:0] conc_mant;
      logic [4:0]  max_exp;
      logic [31:0] max_mant;
   } item_type;

endpackage

[rtl/ldr_front.sv]
// Front end: accepts concentration words, classifies them and normalizes operands.
module ldr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_concentration,
   input  logic [31:0]        conc_limit,
   input  logic [31:0]        scale,
   input  logic               queue_full,
   output logic               push,
   output ldr_pkg::item_type  push_item
);
   import ldr_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     accept;
   logic [31:0] maxc;
   logic [4:0]  ce, me;

   // Return the index of the highest set bit, zero for zero
   function automatic logic [4:0] msb_index(input logic [31:0] v);
      logic [4:0] e;
      e = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) e = 5'(i);
      end
      return e;
   endfunction

   assign busy      = vld_ff && queue_full;
   assign accept    = start && !busy;
   assign push      = vld_ff && !queue_full;
   assign push_item = item_ff;

   // Classify and normalize the incoming word
   always_comb begin
      maxc = (conc_limit == '0) ? 32'd1 : conc_limit;
      ce   = msb_index(req_concentration);
      me   = msb_index(maxc);
      item_in.conc_exp  = ce;
      item_in.conc_mant = req_concentration << (5'd31 - ce);
      item_in.max_exp   = me;
      item_in.max_mant  = maxc << (5'd31 - me);
      item_in.scale_neg = scale[31];
      if (req_concentration > maxc) begin
         item_in.kind = KIND_OVER_MAX;
      end else if (scale == '0) begin
         item_in.kind = KIND_ZERO_SCALE;
      end else if (req_concentration == '0) begin
         item_in.kind = KIND_ZERO_CONC;
      end else begin
         item_in.kind = KIND_NORMAL;
      end
   end

   // Hold the word until the queue takes it
   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

[rtl/ldr_queue.sv]
// Short queue between front end and back end.
module ldr_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ldr_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output ldr_pkg::item_type  head_item
);
   import ldr_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

[rtl/ldr_back.sv]
// Back end: pipelined log2, scale divide, exp2 and reciprocal rounding.
module ldr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ldr_pkg::item_type  in_item,
   input  logic [31:0]        midpoint,
   input  logic [31:0]        scale,
   output logic               rsp_strobe,
   output logic [16:0]        rsp_viability,
   output logic [1:0]         rsp_status
);
   import ldr_pkg::*;

   localparam int unsigned BACK_LATENCY = 76;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [21:0] T_CLAMP = 22'h20_0000;

   typedef logic [31:0] root_table_type [16];

   // Integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem, res, b;
      rem = x;
      res = '0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > rem) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != '0) begin
            if (rem >= res + b) begin
               rem = rem - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Factors 2^(2^-(k+1)) in Q2.30 by successive square roots of 2.0
   function automatic root_table_type make_roots();
      root_table_type t;
      logic [63:0]    r;
      r = 64'd1 << 31;
      for (int k = 0; k < 16; k++) begin
         r    = isqrt64(r << 30);
         t[k] = r[31:0];
      end
      return t;
   endfunction

   localparam root_table_type EXP_ROOTS = make_roots();

   // One squaring step of the log2 mantissa in Q1.31
   function automatic logic [32:0] sq_step(input logic [31:0] m);
      logic [63:0] p;
      logic [32:0] s;
      p = 64'(m) * 64'(m);
      s = p[63:31];
      return s[32] ? {1'b1, s[32:1]} : {1'b0, s[31:0]};
   endfunction

   typedef struct packed {
      kind_type    kind;
      logic        sneg;
      logic [4:0]  ce;
      logic [31:0] cm;
      logic [15:0] cf;
      logic [4:0]  me;
      logic [31:0] mm;
      logic [15:0] mf;
   } lg_type;

   typedef struct packed {
      kind_type    kind;
      logic        sneg;
      logic        sign;
      logic [32:0] abs_u;
      logic [31:0] abs_s;
   } xu_type;

   typedef struct packed {
      kind_type    kind;
      logic        sneg;
      logic        sign;
      logic        ovf;
      logic [31:0] abs_s;
      logic [31:0] rem;
      logic [21:0] nlow;
      logic [21:0] quo;
   } dv_type;

   typedef struct packed {
      kind_type    kind;
      logic        sneg;
      logic        neg;
      logic [21:0] mag;
   } cl_type;

   typedef struct packed {
      kind_type    kind;
      logic        sneg;
      logic        neg;
      logic [5:0]  n;
      logic [15:0] f;
      logic [31:0] m;
   } ex_type;

   typedef struct packed {
      kind_type    kind;
      logic        sneg;
      logic        neg;
      logic        zq;
      logic [51:0] den;
      logic [51:0] rem;
      logic [15:0] nlow;
      logic [15:0] quo;
   } qd_type;

   logic [BACK_LATENCY-1:0] vld_ff, vld_in;
   lg_type lg_src [16];
   lg_type lg_ff [16], lg_in [16];
   xu_type xu_ff, xu_in;
   dv_type dv_ff [23], dv_in [23];
   cl_type cl_ff, cl_in;
   ex_type ex_ff [17], ex_in [17];
   qd_type qd_ff [17], qd_in [17];
   logic [16:0] viab_ff, viab_in;
   logic [1:0]  status_ff, status_in;

   // Log2 of concentration and maximum, one fraction bit per stage
   always_comb begin
      lg_type      cur;
      logic [32:0] c;
      logic [32:0] d;
      lg_src[0].kind = in_item.kind;
      lg_src[0].sneg = in_item.scale_neg;
      lg_src[0].ce   = in_item.conc_exp;
      lg_src[0].cm   = in_item.conc_mant;
      lg_src[0].cf   = '0;
      lg_src[0].me   = in_item.max_exp;
      lg_src[0].mm   = in_item.max_mant;
      lg_src[0].mf   = '0;
      for (int j = 1; j < 16; j++) begin
         lg_src[j] = lg_ff[j-1];
      end
      for (int j = 0; j < 16; j++) begin
         cur = lg_src[j];
         c   = sq_step(cur.cm);
         d   = sq_step(cur.mm);
         cur.cm = c[31:0];
         cur.cf[15-j] = c[32];
         cur.mm = d[31:0];
         cur.mf[15-j] = d[32];
         lg_in[j] = cur;
      end
   end

   // Form x, subtract the midpoint and split signs from magnitudes
   always_comb begin
      logic signed [7:0]  xint;
      logic signed [33:0] xv, uv;
      logic [33:0]        nu;
      xint = $signed({3'b000, lg_ff[15].ce}) - $signed({3'b000, lg_ff[15].me}) + 8'sd9;
      xv   = $signed({{10{xint[7]}}, xint, 16'h0000})
           + $signed({18'b0, lg_ff[15].cf}) - $signed({18'b0, lg_ff[15].mf});
      uv   = xv - $signed({{2{midpoint[31]}}, midpoint});
      nu   = 34'(-uv);
      xu_in.kind  = lg_ff[15].kind;
      xu_in.sneg  = lg_ff[15].sneg;
      xu_in.sign  = uv[33] ^ scale[31];
      xu_in.abs_u = uv[33] ? nu[32:0] : uv[32:0];
      xu_in.abs_s = scale[31] ? (32'd0 - scale) : scale;
   end

   // Restoring divide of |u| * 2^16 by |scale|, one quotient bit per stage
   always_comb begin
      dv_type      cur;
      logic [32:0] r2, diff;
      logic        ge;
      dv_in[0].kind  = xu_ff.kind;
      dv_in[0].sneg  = xu_ff.sneg;
      dv_in[0].sign  = xu_ff.sign;
      dv_in[0].abs_s = xu_ff.abs_s;
      dv_in[0].ovf   = ({5'b0, xu_ff.abs_u[32:6]} >= xu_ff.abs_s);
      dv_in[0].rem   = {5'b0, xu_ff.abs_u[32:6]};
      dv_in[0].nlow  = {xu_ff.abs_u[5:0], 16'h0000};
      dv_in[0].quo   = '0;
      for (int j = 0; j < 22; j++) begin
         cur  = dv_ff[j];
         r2   = {cur.rem, cur.nlow[21-j]};
         ge   = (r2 >= {1'b0, cur.abs_s});
         diff = r2 - {1'b0, cur.abs_s};
         cur.rem = ge ? diff[31:0] : r2[31:0];
         cur.quo = {cur.quo[20:0], ge};
         dv_in[j+1] = cur;
      end
   end

   // Clamp |t| to 32.0 and settle the sign of t
   always_comb begin
      logic big;
      big = dv_ff[22].ovf || (dv_ff[22].quo > T_CLAMP);
      cl_in.kind = dv_ff[22].kind;
      cl_in.sneg = dv_ff[22].sneg;
      cl_in.neg  = dv_ff[22].sign && (dv_ff[22].ovf || (dv_ff[22].quo != '0));
      cl_in.mag  = big ? T_CLAMP : dv_ff[22].quo;
   end

   // Scale by log2(e), then build 2^frac from the root factors
   always_comb begin
      ex_type      cur;
      logic [52:0] zp;
      logic [63:0] p;
      zp = 53'(cl_ff.mag) * 53'(LOG2E_Q30);
      ex_in[0].kind = cl_ff.kind;
      ex_in[0].sneg = cl_ff.sneg;
      ex_in[0].neg  = cl_ff.neg;
      ex_in[0].n    = zp[51:46];
      ex_in[0].f    = zp[45:30];
      ex_in[0].m    = 32'h4000_0000;
      for (int e = 0; e < 16; e++) begin
         cur = ex_ff[e];
         p   = 64'(cur.m) * 64'(EXP_ROOTS[e]);
         if (cur.f[15-e]) begin
            cur.m = p[61:30];
         end
         ex_in[e+1] = cur;
      end
   end

   // Round 2^46 / (2^30 * (1 + 2^z)) by restoring divide, one bit per stage
   always_comb begin
      qd_type      cur;
      logic [51:0] den, num;
      logic [52:0] r2, diff;
      logic        ge;
      den = 52'h4000_0000 + (52'(ex_ff[16].m) << ex_ff[16].n[4:0]);
      num = 52'h4000_0000_0000 + (den >> 1);
      qd_in[0].kind = ex_ff[16].kind;
      qd_in[0].sneg = ex_ff[16].sneg;
      qd_in[0].neg  = ex_ff[16].neg;
      qd_in[0].zq   = (ex_ff[16].n > 6'd20);
      qd_in[0].den  = den;
      qd_in[0].rem  = {16'h0000, num[51:16]};
      qd_in[0].nlow = num[15:0];
      qd_in[0].quo  = '0;
      for (int j = 0; j < 16; j++) begin
         cur  = qd_ff[j];
         r2   = {cur.rem, cur.nlow[15-j]};
         ge   = (r2 >= {1'b0, cur.den});
         diff = r2 - {1'b0, cur.den};
         cur.rem = ge ? diff[51:0] : r2[51:0];
         cur.quo = {cur.quo[14:0], ge};
         qd_in[j+1] = cur;
      end
   end

   // Apply the sign of t and the special cases
   always_comb begin
      logic [16:0] q;
      q = qd_ff[16].zq ? 17'd0 : {1'b0, qd_ff[16].quo};
      case (qd_ff[16].kind)
         KIND_OVER_MAX: begin
            viab_in   = '0;
            status_in = STATUS_OVER_MAX;
         end
         KIND_ZERO_SCALE: begin
            viab_in   = '0;
            status_in = STATUS_ZERO_SCALE;
         end
         KIND_ZERO_CONC: begin
            viab_in   = qd_ff[16].sneg ? 17'd0 : ONE_Q16;
            status_in = STATUS_OK;
         end
         default: begin
            viab_in   = qd_ff[16].neg ? (ONE_Q16 - q) : q;
            status_in = STATUS_OK;
         end
      endcase
   end

   assign vld_in = {vld_ff[BACK_LATENCY-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      lg_ff     <= lg_in;
      xu_ff     <= xu_in;
      dv_ff     <= dv_in;
      cl_ff     <= cl_in;
      ex_ff     <= ex_in;
      qd_ff     <= qd_in;
      viab_ff   <= viab_in;
      status_ff <= status_in;
   end

   assign rsp_strobe    = vld_ff[BACK_LATENCY-1];
   assign rsp_viability = viab_ff;
   assign rsp_status    = status_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##BACK_LATENCY rsp_strobe)
      else $error("result strobe missing after fixed latency");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_viability == '0))
      else $error("error status with nonzero viability");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_viability <= ONE_Q16))
      else $error("viability above one");

endmodule

[rtl/log_dose_logistic_response_unit.sv]
// Top level of the logistic dose-response unit: register file, front end, queue, back end.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------------
//  request  | req_concentration                       | start high, busy low
//  result   | rsp_viability, rsp_status               | rsp_strobe, one cycle, no stall
//  control  | psel penable pwrite paddr pwdata prdata | write at psel&penable&pwrite
//
//  One word is taken per cycle while busy is low. A result passes one front-end stage,
//  the queue and 76 back-end stages (16 log2 squarings, 22 + 16 restoring divide steps,
//  16 exp2 root multiplies and glue stages).
//  Reset is synchronous; the queue and all valid bits clear and registers load defaults.
//  The result side cannot stall; busy rises only if the queue were ever full.
module log_dose_logistic_response_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_concentration,
   output logic        rsp_strobe,
   output logic [16:0] rsp_viability,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ldr_pkg::*;

   localparam logic [1:0]  REG_MAX = 2'd0;
   localparam logic [1:0]  REG_MID = 2'd1;
   localparam logic [1:0]  REG_SCALE = 2'd2;
   localparam logic [31:0] MAX_RESET = 32'h0001_0000;
   localparam logic [31:0] MID_RESET = 32'h0000_0000;
   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   logic [31:0] max_ff, max_in, mid_ff, mid_in, scale_ff, scale_in;
   logic        wr;
   logic        push, full, head_valid;
   item_type    push_item, head_item;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   // Write the addressed register
   always_comb begin
      max_in   = max_ff;
      mid_in   = mid_ff;
      scale_in = scale_ff;
      if (wr) begin
         case (paddr[3:2])
            REG_MAX:   max_in   = pwdata;
            REG_MID:   mid_in   = pwdata;
            REG_SCALE: scale_in = pwdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= MAX_RESET;
         mid_ff   <= MID_RESET;
         scale_ff <= SCALE_RESET;
      end else begin
         max_ff   <= max_in;
         mid_ff   <= mid_in;
         scale_ff <= scale_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (paddr[3:2])
         REG_MAX:   prdata = max_ff;
         REG_MID:   prdata = mid_ff;
         REG_SCALE: prdata = scale_ff;
         default:   prdata = '0;
      endcase
   end

   ldr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_concentration (req_concentration),
      .conc_limit        (max_ff),
      .scale             (scale_ff),
      .queue_full        (full),
      .push              (push),
      .push_item         (push_item)
   );

   ldr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (head_valid),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ldr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (head_valid),
      .in_item       (head_item),
      .midpoint      (mid_ff),
      .scale         (scale_ff),
      .rsp_strobe    (rsp_strobe),
      .rsp_viability (rsp_viability),
      .rsp_status    (rsp_status)
   );

endmodule

[tb/log_dose_logistic_response_unit_tb.sv]
// Testbench for the logistic dose-response unit: exact viability predictor per result word.
`timescale 1ns / 100ps

class viability_scoreboard;
   bit [31:0] conc_limit;
   bit [31:0] midpoint;
   bit [31:0] scale;
   bit [16:0] want_via[$];
   bit [1:0]  want_status[$];
   int        errors;

   function new();
      conc_limit = 32'd65536;
      midpoint = 32'd0;
      scale    = 32'd65536;
      errors   = 0;
   endfunction

   // log2 of a nonzero raw Q16.16 value, Q16.16, fraction by repeated squaring
   function automatic longint log2_fix(bit [31:0] v);
      int        e;
      bit [63:0] m;
      longint    fr;
      e = 31;
      while (e > 0 && v[e] == 1'b0) e--;
      m = 64'(v) << (31 - e);
      fr = 0;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            fr = fr | (longint'(1) << i);
            m = m >> 1;
         end
      end
      return longint'(e - 16) * 65536 + fr;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // round(65536 / (1 + 2^z)), z >= 0 in Q16.16
   function automatic bit [31:0] tail_fraction(bit [63:0] z);
      bit [63:0] n;
      bit [15:0] f;
      bit [63:0] root;
      bit [63:0] m;
      bit [63:0] den;
      n = z >> 16;
      f = z[15:0];
      root = 64'd1 << 31;
      m = 64'd1 << 30;
      if (n > 20) return 0;
      for (int k = 1; k <= 16; k++) begin
         root = int_sqrt(root << 30);
         if (f[16 - k]) m = (m * root) >> 30;
      end
      den = (64'd1 << 30) + (m << n);
      return 32'(((64'd1 << 46) + den / 2) / den);
   endfunction

   // work out the expected word for one accepted dose
   function void note_dose(bit [31:0] conc);
      bit [31:0] maxc;
      longint    mid;
      longint    sc;
      longint    x;
      longint    u;
      longint    t;
      bit [63:0] a;
      bit [31:0] q;
      bit [16:0] via;
      bit [1:0]  st;
      maxc = (conc_limit == 0) ? 32'd1 : conc_limit;
      mid = longint'(signed'(midpoint));
      sc = longint'(signed'(scale));
      st = ldr_pkg::STATUS_OK;
      if (conc > maxc) begin
         st = ldr_pkg::STATUS_OVER_MAX;
         via = 0;
      end else if (sc == 0) begin
         st = ldr_pkg::STATUS_ZERO_SCALE;
         via = 0;
      end else if (conc == 0) begin
         via = (sc > 0) ? 17'd65536 : 17'd0;
      end else begin
         x = log2_fix(conc) - log2_fix(maxc) + 9 * 65536;
         u = x - mid;
         t = (u * 65536) / sc;
         a = (t < 0) ? 64'(-t) : 64'(t);
         if (a > (64'd32 << 16)) a = 64'd32 << 16;
         q = tail_fraction((a * 64'd1549082005) >> 30);
         via = (t < 0) ? 17'(32'd65536 - q) : 17'(q);
      end
      want_via.push_back(via);
      want_status.push_back(st);
   endfunction

   // compare one result word against the oldest expectation
   function void check_result(bit [16:0] via, bit [1:0] st);
      bit [16:0] ev;
      bit [1:0]  es;
      if (want_via.size() == 0) begin
         $display("%0t: unexpected result viability=%0d status=%0d", $time, via, st);
         errors++;
         return;
      end
      ev = want_via.pop_front();
      es = want_status.pop_front();
      if (ev !== via) begin
         $display("%0t: viability expected %0d actual %0d", $time, ev, via);
         errors++;
      end
      if (es !== st) begin
         $display("%0t: status expected %0d actual %0d", $time, es, st);
         errors++;
      end
   endfunction
endclass

module log_dose_logistic_response_unit_tb;
   localparam bit [3:0] ADDR_CONC_LIMIT = 4'h0;
   localparam bit [3:0] ADDR_MIDPOINT = 4'h4;
   localparam bit [3:0] ADDR_SCALE    = 4'h8;
   localparam int LATENCY = 78;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_concentration = '0;
   logic        rsp_strobe;
   logic [16:0] rsp_viability;
   logic [1:0]  rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   viability_scoreboard sb;
   longint cycles = 0;

   log_dose_logistic_response_unit dut (.*);

   always #2 clock = ~clock;

   // note accepted words and check results, pre-edge values
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) sb.note_dose(req_concentration);
         if (rsp_strobe) sb.check_result(rsp_viability, rsp_status);
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // setup and access cycle, then idle the port
   task automatic write_reg(bit [3:0] addr, bit [31:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (addr)
         ADDR_CONC_LIMIT: sb.conc_limit = data;
         ADDR_MIDPOINT:   sb.midpoint = data;
         ADDR_SCALE:      sb.scale = data;
         default: ;
      endcase
   endtask

   task automatic set_curve(bit [31:0] mx, bit [31:0] mid, bit [31:0] sc);
      write_reg(ADDR_CONC_LIMIT, mx);
      write_reg(ADDR_MIDPOINT, mid);
      write_reg(ADDR_SCALE, sc);
   endtask

   // hold start until the word is taken; called at a falling edge
   task automatic send_dose(bit [31:0] conc, int idle_pct);
      while (int'($urandom_range(99)) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_concentration = conc;
      // busy only moves at rising edges, so a low busy here means the next edge takes it
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // stop sending, wait out the pipeline
   task automatic drain();
      start = 1'b0;
      while (sb.want_via.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
   endtask

   function automatic bit [31:0] pick_dose(bit [31:0] mx);
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(32);
         2: return (mx == 0) ? 32'd1 : mx;
         3: return (mx == 32'hFFFF_FFFF) ? mx : mx + 1;
         default: return $urandom_range(mx);
      endcase
   endfunction

   function automatic bit [31:0] pick_signed(int span);
      int v;
      v = int'($urandom_range(2 * span)) - span;
      return 32'(v);
   endfunction

   initial begin
      int idle_mix[4];
      bit [31:0] mx;
      bit [31:0] mid;
      bit [31:0] sc;
      idle_mix = '{0, 78, 12, 0};
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults, then field extremes
      send_dose(32'd0, 0);
      send_dose(32'd1, 0);
      send_dose(32'd65536, 0);
      send_dose(32'd65537, 0);
      send_dose(32'hFFFF_FFFF, 0);
      send_dose(32'd256, 0);
      drain();
      set_curve(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000);
      send_dose(32'd0, 0);
      send_dose(32'hFFFF_FFFF, 0);
      send_dose(32'h8000_0000, 0);
      send_dose(32'd1, 0);
      drain();
      set_curve(32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_dose(32'd0, 0);
      send_dose(32'd1, 0);
      send_dose(32'd2, 0);
      drain();
      set_curve(32'h0010_0000, 32'd9 << 16, 32'h8000_0000);
      send_dose(32'h0010_0000, 0);
      send_dose(32'd12345, 0);
      drain();
      set_curve(32'h0010_0000, 32'd0, 32'd0);
      send_dose(32'd0, 0);
      send_dose(32'd100, 0);
      send_dose(32'h0020_0000, 0);
      drain();
      set_curve(32'h0001_0000, 32'd8 << 16, 32'd1);
      send_dose(32'd40000, 0);
      send_dose(32'd65536, 0);
      drain();

      // random phases with fresh curves
      for (int ph = 0; ph < 8; ph++) begin
         mx = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(1, 32'h0100_0000));
         mid = ($urandom_range(4) == 0) ? 32'($urandom) : pick_signed(16 << 16);
         case ($urandom_range(7))
            0: sc = 32'($urandom);
            1: sc = 32'd0;
            default: sc = pick_signed(4 << 16);
         endcase
         set_curve(mx, mid, sc);
         for (int n = 0; n < 50; n++) send_dose(pick_dose(mx), idle_mix[ph % 4]);
         drain();
      end

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
